// ===== hdl/rict_pkg.sv =====
// shared types and constants of the reference counted inode cache table
package rict_pkg;

   // operation codes carried in func
   localparam logic [2:0] FUNC_GET     = 3'd0;
   localparam logic [2:0] FUNC_DUP     = 3'd1;
   localparam logic [2:0] FUNC_PUT     = 3'd2;
   localparam logic [2:0] FUNC_MARK    = 3'd3;
   localparam logic [2:0] FUNC_SETLINK = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   localparam logic [15:0] REF_MAX = 16'hFFFF;

   // per entry bookkeeping word
   typedef struct packed {
      logic [15:0] refc;
      logic        valid;
      logic [15:0] links;
   } entry_type;

   // lookup key of one entry
   typedef struct packed {
      logic [31:0] dev;
      logic [31:0] ino;
   } key_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic scan;
      logic slot_rd;
      logic apply;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic req_get;
      logic clear_last;
      logic scan_done;
      logic out_free;
   } stat_type;

endpackage

// ===== hdl/rict_ctrl.sv =====
// controller state machine of the inode cache table
module rict_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rict_pkg::stat_type stat,
   output rict_pkg::cmd_type  cmd
);
   import rict_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SLOT_RD,
      S_APPLY
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = stat.req_get ? S_SCAN : S_SLOT_RD;
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_APPLY;
         end
         S_SLOT_RD: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd.load    = (state_ff == S_IDLE) && req_valid;
      cmd.clear   = (state_ff == S_CLEAR);
      cmd.scan    = (state_ff == S_SCAN);
      cmd.slot_rd = (state_ff == S_SLOT_RD);
      cmd.apply   = (state_ff == S_APPLY) && stat.out_free;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== hdl/rict_dp.sv =====
// datapath of the inode cache table: entry memories, scan and update logic
module rict_dp #(
   parameter int ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  rict_pkg::cmd_type  cmd,
   output rict_pkg::stat_type stat,
   input  logic [2:0]         req_func,
   input  logic [31:0]        req_device,
   input  logic [31:0]        req_inode_number,
   input  logic [5:0]         req_slot,
   input  logic [15:0]        req_link_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_result_slot,
   output logic               rsp_hit,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_ref_after,
   output logic               rsp_valid_after
);
   import rict_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] PTR_END  = CW'(ENTRIES);

   // entry memories
   entry_type ent_mem [ENTRIES];
   key_type   key_mem [ENTRIES];

   // transaction registers
   logic [2:0]  func_ff;
   logic [31:0] dev_ff;
   logic [31:0] ino_ff;
   logic [5:0]  slot_ff;
   logic [15:0] link_ff;

   // scan control
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff;
   logic          hit_ff, hit_in;
   logic          free_vld_ff, free_vld_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   // registered memory read data
   entry_type ent_rd_ff;
   key_type   key_rd_ff;

   // response registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_ref_ff, rsp_ref_in;
   logic        rsp_val_ff, rsp_val_in;

   logic          match_now;
   logic          slot_bad;
   logic [IW-1:0] slot_idx;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          ent_we;
   logic          key_we;
   logic [IW-1:0] wr_addr;
   entry_type     ent_wdata;
   logic          upd_ent_we;
   logic          upd_key_we;
   logic [IW-1:0] upd_addr;
   entry_type     upd;
   logic [15:0]   inc_ref;

   assign slot_idx  = IW'(slot_ff);
   assign slot_bad  = (32'(slot_ff) >= 32'(ENTRIES));
   assign match_now = rd_vld_ff && (ent_rd_ff.refc != 16'd0) &&
                      (key_rd_ff.dev == dev_ff) && (key_rd_ff.ino == ino_ff);

   // capture the request transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         dev_ff  <= req_device;
         ino_ff  <= req_inode_number;
         slot_ff <= req_slot;
         link_ff <= req_link_count;
      end
   end

   // read port address
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ptr_ff[IW-1:0];
      if (cmd.scan) begin
         rd_en = (ptr_ff < PTR_END) && !match_now;
      end else if (cmd.slot_rd) begin
         rd_en   = 1'b1;
         rd_addr = slot_idx;
      end
   end

   // pointer, read tracking and free entry search
   always_comb begin
      ptr_in      = ptr_ff;
      rd_vld_in   = rd_vld_ff;
      hit_in      = hit_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      if (cmd.load) begin
         ptr_in      = '0;
         rd_vld_in   = 1'b0;
         hit_in      = 1'b0;
         free_vld_in = 1'b0;
      end else if (cmd.clear) begin
         ptr_in = ptr_ff + CW'(1);
      end else if (cmd.scan) begin
         if (rd_en) ptr_in = ptr_ff + CW'(1);
         rd_vld_in = rd_en;
         if (match_now) hit_in = 1'b1;
         if (rd_vld_ff && !free_vld_ff && (ent_rd_ff.refc == 16'd0)) begin
            free_vld_in = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end else if (cmd.slot_rd) begin
         rd_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         hit_ff      <= 1'b0;
         free_vld_ff <= 1'b0;
      end else begin
         ptr_ff      <= ptr_in;
         rd_vld_ff   <= rd_vld_in;
         hit_ff      <= hit_in;
         free_vld_ff <= free_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
   end

   // memory read with registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         ent_rd_ff <= ent_mem[rd_addr];
         key_rd_ff <= key_mem[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   assign inc_ref = (ent_rd_ff.refc == REF_MAX) ? REF_MAX : ent_rd_ff.refc + 16'd1;

   // update of the addressed entry and the result fields
   always_comb begin
      upd           = ent_rd_ff;
      upd_ent_we    = 1'b0;
      upd_key_we    = 1'b0;
      upd_addr      = rd_idx_ff;
      rsp_slot_in   = 6'(rd_idx_ff);
      rsp_hit_in    = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_ref_in    = ent_rd_ff.refc;
      rsp_val_in    = ent_rd_ff.valid;
      if (func_ff == FUNC_GET) begin
         if (hit_ff) begin
            upd.refc   = inc_ref;
            upd_ent_we = 1'b1;
            rsp_hit_in = 1'b1;
            rsp_ref_in = inc_ref;
         end else if (free_vld_ff) begin
            upd.refc    = 16'd1;
            upd.valid   = 1'b0;
            upd.links   = 16'd0;
            upd_ent_we  = 1'b1;
            upd_key_we  = 1'b1;
            upd_addr    = free_idx_ff;
            rsp_slot_in = 6'(free_idx_ff);
            rsp_ref_in  = 16'd1;
            rsp_val_in  = 1'b0;
         end else begin
            rsp_slot_in   = 6'd0;
            rsp_status_in = STATUS_FULL;
            rsp_ref_in    = 16'd0;
            rsp_val_in    = 1'b0;
         end
      end else if (slot_bad) begin
         rsp_slot_in   = slot_ff;
         rsp_status_in = STATUS_ERROR;
         rsp_ref_in    = 16'd0;
         rsp_val_in    = 1'b0;
      end else begin
         case (func_ff)
            FUNC_DUP: begin
               upd.refc   = inc_ref;
               upd_ent_we = 1'b1;
               rsp_ref_in = inc_ref;
            end
            FUNC_PUT: begin
               if (ent_rd_ff.refc == 16'd0) begin
                  rsp_status_in = STATUS_ERROR;
                  rsp_ref_in    = 16'd0;
               end else begin
                  if ((ent_rd_ff.refc == 16'd1) && (ent_rd_ff.links == 16'd0)) begin
                     upd.valid = 1'b0;
                  end
                  upd.refc   = ent_rd_ff.refc - 16'd1;
                  upd_ent_we = 1'b1;
                  rsp_ref_in = upd.refc;
                  rsp_val_in = upd.valid;
               end
            end
            FUNC_MARK: begin
               if (ent_rd_ff.refc == 16'd0) begin
                  rsp_status_in = STATUS_ERROR;
                  rsp_ref_in    = 16'd0;
               end else begin
                  upd.valid  = 1'b1;
                  upd_ent_we = 1'b1;
                  rsp_val_in = 1'b1;
               end
            end
            FUNC_SETLINK: begin
               upd.links  = link_ff;
               upd_ent_we = 1'b1;
            end
            default: begin
               upd_ent_we = 1'b0;
            end
         endcase
      end
   end

   // write port: clearing pass after reset or the entry update
   always_comb begin
      ent_we    = 1'b0;
      key_we    = 1'b0;
      wr_addr   = upd_addr;
      ent_wdata = upd;
      if (cmd.clear) begin
         ent_we    = 1'b1;
         wr_addr   = ptr_ff[IW-1:0];
         ent_wdata = '0;
      end else if (cmd.apply) begin
         ent_we = upd_ent_we;
         key_we = upd_key_we;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[wr_addr] <= ent_wdata;
      if (key_we) key_mem[wr_addr] <= '{dev: dev_ff, ino: ino_ff};
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_status_ff <= rsp_status_in;
         rsp_ref_ff    <= rsp_ref_in;
         rsp_val_ff    <= rsp_val_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_ref_after   = rsp_ref_ff;
   assign rsp_valid_after = rsp_val_ff;

   // status to the controller
   always_comb begin
      stat.req_get    = (req_func == FUNC_GET);
      stat.clear_last = (ptr_ff[IW-1:0] == LAST_IDX);
      stat.scan_done  = rd_vld_ff && (match_now || (rd_idx_ff == LAST_IDX));
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== hdl/refcounted_inode_cache_table.sv =====
// Reference counted inode cache table, top level. After reset the table runs a clearing
// pass over every entry of its count memory and takes no transaction until it ends.
// One transaction is worked at a time. Dup, put, mark valid and set link count go from
// acceptance to result through accept, memory read and update. A get walks the
// table through the single read port of the entry memories, one entry per cycle, and
// stops at a hit or else after the last entry. The result register frees the input side,
// so the next transaction is accepted while a result still waits to be taken.
module refcounted_inode_cache_table #(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_device,
   input  logic [31:0] req_inode_number,
   input  logic [5:0]  req_slot,
   input  logic [15:0] req_link_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_result_slot,
   output logic        rsp_hit,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_ref_after,
   output logic        rsp_valid_after
);
   import rict_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   rict_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // memories and update logic
   rict_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_device       (req_device),
      .req_inode_number (req_inode_number),
      .req_slot         (req_slot),
      .req_link_count   (req_link_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_hit          (rsp_hit),
      .rsp_status       (rsp_status),
      .rsp_ref_after    (rsp_ref_after),
      .rsp_valid_after  (rsp_valid_after)
   );

endmodule
